FILE: hw/rtl/alst_pkg.sv
// Shared types, status codes and helpers for the alarm schedule table.
`timescale 1ns / 1ps
package alst_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_FIRED    = 4'd1;
  localparam logic [3:0] ST_TICK     = 4'd2;
  localparam logic [3:0] ST_FULL     = 4'd3;
  localparam logic [3:0] ST_NOTFOUND = 4'd4;
  localparam logic [3:0] ST_HOUR     = 4'd5;
  localparam logic [3:0] ST_MINUTE   = 4'd6;
  localparam logic [3:0] ST_MASK     = 4'd7;
  localparam logic [3:0] ST_YEAR     = 4'd8;
  localparam logic [3:0] ST_MONTH    = 4'd9;
  localparam logic [3:0] ST_DAY      = 4'd10;

  localparam logic [4:0]  MAX_HOUR   = 5'd23;
  localparam logic [5:0]  MAX_MINUTE = 6'd59;
  localparam logic [11:0] MIN_YEAR   = 12'd2020;
  localparam logic [11:0] MAX_YEAR   = 12'd2099;
  localparam logic [3:0]  MAX_MONTH  = 4'd12;
  localparam logic [4:0]  MAX_DAY    = 5'd31;

  // Command broadcast to every cell for the duration of a scan.
  typedef struct packed {
    op_t         op;
    logic [7:0]  id;
    logic        enabled;
    logic        recurring;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  wday_mask;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  dow_bit;
    logic [31:0] stamp;
    logic        time_valid;
    logic        data_ok;
    logic [7:0]  new_id;
  } cmd_t;

  function automatic logic [3:0] check_data(input logic rec, input logic [4:0] hour,
                                            input logic [5:0] minute,
                                            input logic [6:0] mask,
                                            input logic [11:0] year,
                                            input logic [3:0] month,
                                            input logic [4:0] day);
    logic [3:0] st;
    st = ST_OK;
    if (hour > MAX_HOUR) st = ST_HOUR;
    else if (minute > MAX_MINUTE) st = ST_MINUTE;
    else if (rec) st = (mask == 7'd0) ? ST_MASK : ST_OK;
    else if (year < MIN_YEAR || year > MAX_YEAR) st = ST_YEAR;
    else if (month == 4'd0 || month > MAX_MONTH) st = ST_MONTH;
    else if (day == 5'd0 || day > MAX_DAY) st = ST_DAY;
    return st;
  endfunction

  // Sunday-first weekday to Monday-first mask bit; seven matches nothing.
  function automatic logic [6:0] dow_bit(input logic [2:0] wd);
    logic [6:0] b;
    b = 7'd0;
    if (wd == 3'd0) b = 7'b1000000;
    else if (wd != 3'd7) b = 7'(7'd1 << (wd - 3'd1));
    return b;
  endfunction

endpackage

FILE: hw/rtl/alst_cell.sv
// One table slot: entry, last-fired stamp and the scan token it hands on.
`timescale 1ns / 1ps
module alst_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  alst_pkg::cmd_t   cmd,
  input  logic             start,
  input  logic             step,
  input  logic             token_in,
  input  logic             done_in,
  output logic             token_out,
  output logic             done_out,
  output logic             act,
  output logic [7:0]       ent_id
);

  logic        token_r, done_r;
  logic        used_r, en_r, rec_r, lfv_r;
  logic [7:0]  id_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [6:0]  mask_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [31:0] stamp_r;
  logic        match, fire, hit;

  assign match = used_r && (id_r == cmd.id);
  assign fire  = cmd.time_valid && used_r && en_r && hour_r == cmd.hour &&
                 minute_r == cmd.minute && !(lfv_r && stamp_r == cmd.stamp) &&
                 (rec_r ? |(mask_r & cmd.dow_bit)
                        : (year_r == cmd.year && month_r == cmd.month && day_r == cmd.day));

  always_comb begin
    case (cmd.op)
      alst_pkg::OP_TICK:   hit = fire;
      alst_pkg::OP_ADD:    hit = !done_r && !used_r;
      alst_pkg::OP_UPDATE: hit = cmd.data_ok && !done_r && match;
      alst_pkg::OP_REMOVE: hit = !done_r && match;
      default:             hit = 1'b0;
    endcase
  end

  assign act       = token_r && hit;
  assign token_out = token_r;
  assign done_out  = done_r || act;
  assign ent_id    = id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= 1'b0;
      done_r  <= 1'b0;
      used_r  <= 1'b0;
      lfv_r   <= 1'b0;
      en_r    <= 1'b0;
    end else begin
      if (start) begin
        token_r <= token_in;
        done_r  <= 1'b0;
      end else if (step) begin
        token_r <= token_in;
        done_r  <= done_in;
      end
      if (step && act) begin
        case (cmd.op)
          alst_pkg::OP_TICK: begin
            lfv_r   <= 1'b1;
            stamp_r <= cmd.stamp;
            if (!rec_r) en_r <= 1'b0;
          end
          alst_pkg::OP_ADD, alst_pkg::OP_UPDATE: begin
            if (cmd.data_ok) begin
              used_r   <= 1'b1;
              id_r     <= (cmd.op == alst_pkg::OP_ADD) ? cmd.new_id : cmd.id;
              en_r     <= cmd.enabled;
              rec_r    <= cmd.recurring;
              hour_r   <= cmd.hour;
              minute_r <= cmd.minute;
              mask_r   <= cmd.wday_mask;
              year_r   <= cmd.year;
              month_r  <= cmd.month;
              day_r    <= cmd.day;
              lfv_r    <= 1'b0;
            end
          end
          default: begin
            used_r <= 1'b0;
            en_r   <= 1'b0;
            lfv_r  <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/alarm_schedule_table_core.sv
// Top level of the alarm schedule table: request intake, cell chain, result stage.
`timescale 1ns / 1ps
// Usage:
//  Requests arrive on in_t* (tick, add, update by id, remove by id); results
//  leave on out_t* with out_tlast marking the final result of a request.
//  A request is taken only while the block is idle. A scan token then walks
//  the chain of MAX_EVENTS cells, one cell per cycle while the output is free;
//  each cell checks its own slot and updates it in place. A tick emits one
//  "fired" result per matching slot in slot order, then a "tick done" result.
//  Add, update and remove give one result after the scan.
//  The final result is loaded after the token has passed the last cell; one
//  request at a time, so the next request is taken only once the final
//  result of the last one is loaded and the block is idle again.
//  A single output register holds each result; while the receiver stalls
//  the scan holds its place and no cell advances.
//  Reset empties the table, clears all last-fired stamps and sets the next
//  id to 1.
module alarm_schedule_table_core #(
  parameter int MAX_EVENTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0], event_id[9:2], enabled[10], recurring[11], hour[16:12],
  // minute[22:17], wday_mask[29:23], year[41:30], month[45:42], day[50:46],
  // weekday[53:51], time_valid[54]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[3:0], result_id[11:4], slot[15:12]
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_EVENTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL} state_t;

  state_t          state_r;
  alst_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [3:0]      st_r;
  logic [7:0]      next_id_r;
  logic [IW-1:0]   idx_r;
  logic            found_r;
  logic [3:0]      fslot_r;
  logic            out_valid_r, out_last_r;
  logic [3:0]      out_status_r, out_slot_r;
  logic [7:0]      out_id_r;

  logic            start, step, out_free, act_sel, out_load;
  logic [7:0]      id_sel;
  logic [3:0]      slot_cur;
  logic [3:0]      st_in;

  logic [MAX_EVENTS:0] token_c, done_c;
  logic [MAX_EVENTS-1:0] act_a;
  logic [7:0]      id_a [MAX_EVENTS];

  assign in_tready  = (state_r == S_IDLE);
  assign start      = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign step       = (state_r == S_SCAN) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_slot_r, out_id_r, out_status_r};

  assign st_in = alst_pkg::check_data(in_tdata[11], in_tdata[16:12], in_tdata[22:17],
                                      in_tdata[29:23], in_tdata[41:30], in_tdata[45:42],
                                      in_tdata[50:46]);

  always_comb begin
    cmd_nxt.op         = alst_pkg::op_t'(in_tdata[1:0]);
    cmd_nxt.id         = in_tdata[9:2];
    cmd_nxt.enabled    = in_tdata[10];
    cmd_nxt.recurring  = in_tdata[11];
    cmd_nxt.hour       = in_tdata[16:12];
    cmd_nxt.minute     = in_tdata[22:17];
    cmd_nxt.wday_mask  = in_tdata[29:23];
    cmd_nxt.year       = in_tdata[41:30];
    cmd_nxt.month      = in_tdata[45:42];
    cmd_nxt.day        = in_tdata[50:46];
    cmd_nxt.dow_bit    = alst_pkg::dow_bit(in_tdata[53:51]);
    cmd_nxt.stamp      = {in_tdata[41:30], in_tdata[45:42], in_tdata[50:46],
                          in_tdata[16:12], in_tdata[22:17]};
    cmd_nxt.time_valid = in_tdata[54];
    cmd_nxt.data_ok    = (st_in == alst_pkg::ST_OK);
    cmd_nxt.new_id     = next_id_r;
  end

  // Token enters cell 0 on accept and moves one cell per scan step.
  assign token_c[0] = start;
  assign done_c[0]  = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_EVENTS; g++) begin : g_cell
      alst_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_r),
        .start    (start),
        .step     (step),
        .token_in (token_c[g]),
        .done_in  (done_c[g]),
        .token_out(token_c[g+1]),
        .done_out (done_c[g+1]),
        .act      (act_a[g]),
        .ent_id   (id_a[g])
      );
    end
  endgenerate

  assign act_sel  = act_a[idx_r];
  assign id_sel   = id_a[idx_r];
  assign slot_cur = 4'(idx_r);

  // Output register is loaded this cycle (fired result or final result).
  assign out_load = (step && act_sel && cmd_r.op == alst_pkg::OP_TICK) ||
                    (state_r == S_FINAL && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_id_r   <= 8'd1;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_tready && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd_nxt;
            st_r    <= st_in;
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step) begin
            if (act_sel) begin
              if (cmd_r.op == alst_pkg::OP_TICK) begin
                out_valid_r  <= 1'b1;
                out_last_r   <= 1'b0;
                out_status_r <= alst_pkg::ST_FIRED;
                out_id_r     <= id_sel;
                out_slot_r   <= slot_cur;
              end else begin
                found_r <= 1'b1;
                fslot_r <= slot_cur;
              end
            end
            if (idx_r == LAST_IDX) state_r <= S_FINAL;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_last_r   <= 1'b1;
            out_status_r <= alst_pkg::ST_OK;
            out_id_r     <= 8'd0;
            out_slot_r   <= 4'd0;
            case (cmd_r.op)
              alst_pkg::OP_TICK: out_status_r <= alst_pkg::ST_TICK;
              alst_pkg::OP_ADD: begin
                if (!found_r) out_status_r <= alst_pkg::ST_FULL;
                else if (st_r != alst_pkg::ST_OK) out_status_r <= st_r;
                else begin
                  out_id_r   <= next_id_r;
                  out_slot_r <= fslot_r;
                  next_id_r  <= (next_id_r == 8'hFF) ? 8'd1 : next_id_r + 8'd1;
                end
              end
              alst_pkg::OP_UPDATE: begin
                if (st_r != alst_pkg::ST_OK) out_status_r <= st_r;
                else if (!found_r) out_status_r <= alst_pkg::ST_NOTFOUND;
                else begin
                  out_id_r   <= cmd_r.id;
                  out_slot_r <= fslot_r;
                end
              end
              default: begin
                if (!found_r) out_status_r <= alst_pkg::ST_NOTFOUND;
                else begin
                  out_id_r   <= cmd_r.id;
                  out_slot_r <= fslot_r;
                end
              end
            endcase
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/tb_alarm_schedule_table_core.sv
// Self-checking testbench for the alarm schedule table core.
`timescale 1ns / 1ps
module tb_alarm_schedule_table_core;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic        time_valid;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [6:0]  wday_mask;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic        recurring;
    logic        enabled;
    logic [7:0]  event_id;
    alst_pkg::op_t op;
  } request_t;

  typedef struct packed {
    logic        last;
    logic [3:0]  slot;
    logic [7:0]  id;
    logic [3:0]  status;
  } result_t;

  typedef struct {
    logic        used;
    logic [7:0]  id;
    logic        enabled;
    logic        recurring;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  mask;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } alarm_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [55:0] in_tdata;
  logic [15:0] out_tdata;

  alarm_schedule_table_core #(.MAX_EVENTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // predictor state
  alarm_t      alarms [SLOTS];
  logic        stamp_ok [SLOTS];
  logic [31:0] stamp_val [SLOTS];
  logic [7:0]  id_ctr;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       mismatches = 0;
  bit       calm = 1'b0;        // no random idling while set
  int       hold_off = 0;       // long receiver stall, counted in cycles
  bit       stall_go = 1'b0;    // asks for the long stall
  bit       stall_taken = 1'b0;
  logic [7:0] issued_ids[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [3:0] validate(request_t r);
    if (r.hour > alst_pkg::MAX_HOUR) return alst_pkg::ST_HOUR;
    if (r.minute > alst_pkg::MAX_MINUTE) return alst_pkg::ST_MINUTE;
    if (r.recurring) return (r.wday_mask == 7'd0) ? alst_pkg::ST_MASK : alst_pkg::ST_OK;
    if (r.year < alst_pkg::MIN_YEAR || r.year > alst_pkg::MAX_YEAR) return alst_pkg::ST_YEAR;
    if (r.month == 4'd0 || r.month > alst_pkg::MAX_MONTH) return alst_pkg::ST_MONTH;
    if (r.day == 5'd0) return alst_pkg::ST_DAY;
    return alst_pkg::ST_OK;
  endfunction

  function automatic void push_result(logic [3:0] st, logic [7:0] id, logic [3:0] sl,
                                      logic lst);
    result_t r;
    r.status = st; r.id = id; r.slot = sl; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void store_alarm(int s, request_t r, logic [7:0] id);
    alarms[s].used = 1'b1; alarms[s].id = id; alarms[s].enabled = r.enabled;
    alarms[s].recurring = r.recurring; alarms[s].hour = r.hour;
    alarms[s].minute = r.minute; alarms[s].mask = r.wday_mask;
    alarms[s].year = r.year; alarms[s].month = r.month; alarms[s].day = r.day;
    stamp_ok[s] = 1'b0; stamp_val[s] = 32'd0;
  endfunction

  function automatic int lookup(logic [7:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (alarms[i].used && alarms[i].id == id) return i;
    return -1;
  endfunction

  function automatic int lookup_free();
    for (int i = 0; i < SLOTS; i++)
      if (!alarms[i].used) return i;
    return -1;
  endfunction

  // Schedule-table prediction for one accepted request.
  function automatic void predict_schedule(request_t r);
    logic [31:0] stamp;
    logic [6:0]  bitm;
    logic [3:0]  st;
    logic        hit;
    int          s;
    case (r.op)
      alst_pkg::OP_TICK: begin
        stamp = (32'(r.year) << 20) | (32'(r.month) << 16) | (32'(r.day) << 11) |
                (32'(r.hour) << 6) | 32'(r.minute);
        bitm = (r.weekday == 3'd7) ? 7'd0 : 7'(1 << ((r.weekday + 6) % 7));
        if (r.time_valid) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!alarms[i].used || !alarms[i].enabled) continue;
            if (alarms[i].hour != r.hour || alarms[i].minute != r.minute) continue;
            if (stamp_ok[i] && stamp_val[i] == stamp) continue;
            if (alarms[i].recurring) hit = (alarms[i].mask & bitm) != 7'd0;
            else hit = alarms[i].year == r.year && alarms[i].month == r.month &&
                       alarms[i].day == r.day;
            if (!hit) continue;
            push_result(alst_pkg::ST_FIRED, alarms[i].id, 4'(i), 1'b0);
            stamp_ok[i] = 1'b1; stamp_val[i] = stamp;
            if (!alarms[i].recurring) alarms[i].enabled = 1'b0;
          end
        end
        push_result(alst_pkg::ST_TICK, 8'd0, 4'd0, 1'b1);
      end
      alst_pkg::OP_ADD: begin
        s = lookup_free();
        if (s < 0) push_result(alst_pkg::ST_FULL, 8'd0, 4'd0, 1'b1);
        else begin
          st = validate(r);
          if (st != alst_pkg::ST_OK) push_result(st, 8'd0, 4'd0, 1'b1);
          else begin
            store_alarm(s, r, id_ctr);
            push_result(alst_pkg::ST_OK, id_ctr, 4'(s), 1'b1);
            issued_ids.push_back(id_ctr);
            id_ctr = (id_ctr == 8'd255) ? 8'd1 : id_ctr + 8'd1;
          end
        end
      end
      alst_pkg::OP_UPDATE: begin
        st = validate(r);
        s = lookup(r.event_id);
        if (st != alst_pkg::ST_OK) push_result(st, 8'd0, 4'd0, 1'b1);
        else if (s < 0) push_result(alst_pkg::ST_NOTFOUND, 8'd0, 4'd0, 1'b1);
        else begin
          store_alarm(s, r, r.event_id);
          push_result(alst_pkg::ST_OK, r.event_id, 4'(s), 1'b1);
        end
      end
      default: begin
        s = lookup(r.event_id);
        if (s < 0) push_result(alst_pkg::ST_NOTFOUND, 8'd0, 4'd0, 1'b1);
        else begin
          alarms[s] = '{default: '0};
          stamp_ok[s] = 1'b0; stamp_val[s] = 32'd0;
          push_result(alst_pkg::ST_OK, r.event_id, 4'(s), 1'b1);
        end
      end
    endcase
  endfunction

  // Driver: one request at a time from the pending queue; the offered request
  // stays at the front until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (in_tvalid && !in_tready) begin
      // hold the offered request
    end else begin
      if (in_tvalid) begin
        predict_schedule(request_t'(in_tdata[54:0]));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, pending_reqs[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver stall, counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end else if (stall_go && !stall_taken) begin
      hold_off    <= 300;
      stall_taken <= 1'b1;
    end
  end

  // Monitor: receiver readiness and result checks.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata[15:0]};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.id !== want.id ||
              got.slot !== want.slot || got.last !== want.last) begin
            $display("%0t: result mismatch, expected st=%0d id=%0d slot=%0d last=%0d,",
                     $time, want.status, want.id, want.slot, want.last);
            $display("%0t:   actual st=%0d id=%0d slot=%0d last=%0d", $time,
                     got.status, got.id, got.slot, got.last);
            mismatches++;
          end
        end
      end
      if (hold_off > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(99) >= 19;
      end
    end
  end

  function automatic request_t rand_req();
    request_t r;
    r = request_t'(55'({$urandom, $urandom}));
    r.op = alst_pkg::op_t'($urandom_range(3));
    return r;
  endfunction

  // Well-formed alarm data with random content; times mostly on a small grid.
  function automatic request_t good_alarm(alst_pkg::op_t op, logic [7:0] id);
    request_t r;
    r = rand_req();
    r.op = op; r.event_id = id;
    r.enabled = ($urandom_range(9) != 0);
    r.hour = 5'($urandom_range(1) ? 7 : $urandom_range(23));
    r.minute = 6'($urandom_range(1) ? 30 : $urandom_range(59));
    r.wday_mask = 7'($urandom_range(127, 1));
    r.year = 12'($urandom_range(2021, 2020));
    r.month = 4'($urandom_range(2, 1));
    r.day = 5'($urandom_range(2, 1));
    return r;
  endfunction

  function automatic request_t tick_at(logic [4:0] h, logic [5:0] m);
    request_t r;
    r = rand_req();
    r.op = alst_pkg::OP_TICK; r.hour = h; r.minute = m; r.time_valid = 1'b1;
    r.year = 12'($urandom_range(2021, 2020));
    r.month = 4'($urandom_range(2, 1));
    r.day = 5'($urandom_range(2, 1));
    r.weekday = 3'($urandom_range(7));
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  initial begin
    request_t r;
    logic [7:0] pick;
    rst_n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      alarms[i] = '{default: '0};
      stamp_ok[i] = 1'b0; stamp_val[i] = 32'd0;
    end
    id_ctr = 8'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: validation of each field, edges of the ranges
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.hour = 5'd24; pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.hour = 5'd31; r.minute = 6'd63;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.minute = 6'd60; pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.recurring = 1'b1; r.wday_mask = 7'd0;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.recurring = 1'b0; r.year = 12'd2019;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.recurring = 1'b0; r.year = 12'd4095;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.recurring = 1'b0; r.month = 4'd0;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.recurring = 1'b0; r.month = 4'd13;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.recurring = 1'b0; r.day = 5'd0;
    pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.enabled = 1'b1; r.recurring = 1'b1;
    r.hour = 5'd23; r.minute = 6'd59; r.wday_mask = 7'h7f; pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_ADD, 8'd0); r.enabled = 1'b1; r.recurring = 1'b0;
    r.hour = 5'd0; r.minute = 6'd0;
    r.year = 12'd2099; r.month = 4'd12; r.day = 5'd31; pending_reqs.push_back(r);
    r = tick_at(5'd23, 6'd59); r.weekday = 3'd0; pending_reqs.push_back(r);
    r = tick_at(5'd23, 6'd59); r.weekday = 3'd0;
    pending_reqs.push_back(r);   // same minute, no refire
    r = tick_at(5'd23, 6'd59); r.weekday = 3'd7; r.day = 5'd3; pending_reqs.push_back(r);
    r = tick_at(5'd0, 6'd0); r.year = 12'd2099; r.month = 4'd12; r.day = 5'd31;
    pending_reqs.push_back(r);
    r = tick_at(5'd0, 6'd0); r.year = 12'd2099; r.month = 4'd12; r.day = 5'd31;
    r.minute = 6'd1; pending_reqs.push_back(r);
    r = tick_at(5'd23, 6'd59); r.time_valid = 1'b0; r.day = 5'd5; r.weekday = 3'd1;
    pending_reqs.push_back(r);
    r = tick_at(5'd31, 6'd63); pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_UPDATE, 8'd1); r.hour = 5'd24; pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_UPDATE, 8'd200); pending_reqs.push_back(r);
    r = good_alarm(alst_pkg::OP_UPDATE, 8'd1); pending_reqs.push_back(r);
    r = rand_req(); r.op = alst_pkg::OP_REMOVE; r.event_id = 8'd2; pending_reqs.push_back(r);
    r = rand_req(); r.op = alst_pkg::OP_REMOVE; r.event_id = 8'd2; pending_reqs.push_back(r);
    r = rand_req(); r.op = alst_pkg::OP_REMOVE; r.event_id = 8'd0; pending_reqs.push_back(r);
    drain();

    // fill the table past full while the receiver stalls
    for (int i = 0; i < SLOTS + 2; i++)
      pending_reqs.push_back(good_alarm(alst_pkg::OP_ADD, 8'd0));
    stall_go = 1'b1;
    drain();

    // random: mostly valid traffic on live ids, some noise
    for (int n = 0; n < 118; n++) begin
      calm = (n >= 60 && n < 90);
      pick = issued_ids.size() ? issued_ids[$urandom_range(issued_ids.size() - 1)]
                               : 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2: r = tick_at(5'($urandom_range(1) ? 7 : $urandom_range(23)),
                             6'($urandom_range(1) ? 30 : $urandom_range(59)));
        3:       r = good_alarm(alst_pkg::OP_ADD, 8'd0);
        4:       r = good_alarm(alst_pkg::OP_UPDATE, pick);
        5:       begin r = rand_req(); r.op = alst_pkg::OP_REMOVE; r.event_id = pick; end
        default: r = rand_req();
      endcase
      pending_reqs.push_back(r);
      if (n % 40 == 39) drain();
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
